### rtl/frt_pkg.sv
// shared types, constants and codes for the flow record table
package frt_pkg;

    localparam int SLOTS     = 256;
    localparam int KEY_BYTES = 13;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = (SLOT_W + 1 > 9) ? SLOT_W + 1 : 9;
    localparam int KEY_W     = 104;
    localparam int KEY_BITS  = (KEY_BYTES * 8 > KEY_W) ? KEY_W : KEY_BYTES * 8;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ST_UPDATE = 2'd0;
    localparam logic [1:0] ST_NEW    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [31:0]      ts_seconds;
        logic [19:0]      ts_micros;
        logic [15:0]      packet_length;
        logic [7:0]       hop_limit;
    } item_t;

    typedef struct packed {
        logic [31:0] packets;
        logic [39:0] bytes;
        logic [15:0] len_min;
        logic [15:0] len_max;
        logic [7:0]  hop_min;
        logic [7:0]  hop_max;
        logic [31:0] start_seconds;
        logic [19:0] start_micros;
    } rec_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        rec_t        rec;
        logic [31:0] new_flow_count;
        logic [31:0] update_count;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_REC,
        S_UPD,
        S_DECIDE
    } back_state_t;

endpackage

### rtl/frt_ram.sv
// generic single write, single read ram with registered read data
module frt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/frt_front.sv
// input side: takes packet beats, masks the key and queues them for the back end
module frt_front import frt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] key_low,
    input  logic [39:0] key_high,
    input  logic [31:0] ts_seconds,
    input  logic [19:0] ts_micros,
    input  logic [15:0] packet_length,
    input  logic [7:0]  hop_limit,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push;
    logic              pop;
    item_t             in_item;

    always_comb
    begin
        in_item.key           = {key_high, key_low} & KEY_MASK;
        in_item.ts_seconds    = ts_seconds;
        in_item.ts_micros     = ts_micros;
        in_item.packet_length = packet_length;
        in_item.hop_limit     = hop_limit;
    end

    assign in_stall = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/frt_back.sv
// back end: scans keys, updates/creates the record or flags full, holds result
module frt_back import frt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    input  logic [8:0] slots_in_use,
    output logic       res_valid,
    output res_t       res,
    input  logic       res_stall
);

    back_state_t      state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [CNT_W-1:0] next_free_reg;
    logic [31:0]      created_reg;
    logic [31:0]      matched_reg;
    item_t            item_reg;
    res_t             out_reg, out_next;
    logic             out_valid_reg;

    logic             key_rd_en, rec_rd_en;
    logic             key_wr_en, rec_wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [KEY_W-1:0] key_rd;
    rec_t             rec_rd;
    rec_t             rec_wr;
    rec_t             upd_rec, new_rec;
    logic             out_free;
    logic             load;
    logic             key_hit;
    logic             scan_last;
    logic             has_room;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] slots_ext;
    logic [40:0]      byte_sum;
    logic [31:0]      created_next, matched_next;

    frt_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_reg.key),
        .rd_en   (key_rd_en),
        .rd_addr (idx_reg),
        .rd_data (key_rd)
    );

    frt_ram #(.WIDTH($bits(rec_t)), .DEPTH(SLOTS)) u_rec_ram (
        .clk     (clk),
        .wr_en   (rec_wr_en),
        .wr_addr (wr_addr),
        .wr_data (rec_wr),
        .rd_en   (rec_rd_en),
        .rd_addr (idx_reg),
        .rd_data (rec_rd)
    );

    assign out_free  = !out_valid_reg || !res_stall;
    assign key_hit   = (key_rd == item_reg.key);
    assign scan_last = ((CNT_W'(idx_reg) + 1'b1) == next_free_reg);
    assign slots_ext = CNT_W'(slots_in_use);
    assign limit     = (slots_ext > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slots_ext;
    assign has_room  = (next_free_reg < limit);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // record arithmetic
    always_comb
    begin
        byte_sum        = {1'b0, rec_rd.bytes} + 41'(item_reg.packet_length);
        upd_rec         = rec_rd;
        upd_rec.packets = (rec_rd.packets == '1) ? rec_rd.packets : rec_rd.packets + 1'b1;
        upd_rec.bytes   = byte_sum[40] ? '1 : byte_sum[39:0];
        if (item_reg.packet_length < rec_rd.len_min)
        begin
            upd_rec.len_min = item_reg.packet_length;
        end
        if (item_reg.packet_length > rec_rd.len_max)
        begin
            upd_rec.len_max = item_reg.packet_length;
        end
        if (item_reg.hop_limit < rec_rd.hop_min)
        begin
            upd_rec.hop_min = item_reg.hop_limit;
        end
        if (item_reg.hop_limit > rec_rd.hop_max)
        begin
            upd_rec.hop_max = item_reg.hop_limit;
        end

        new_rec.packets       = 32'd1;
        new_rec.bytes         = 40'(item_reg.packet_length);
        new_rec.len_min       = item_reg.packet_length;
        new_rec.len_max       = item_reg.packet_length;
        new_rec.hop_min       = item_reg.hop_limit;
        new_rec.hop_max       = item_reg.hop_limit;
        new_rec.start_seconds = item_reg.ts_seconds;
        new_rec.start_micros  = item_reg.ts_micros;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (next_free_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (key_hit)
                begin
                    state_next = S_REC;
                end
                else if (scan_last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_REC:
            begin
                state_next = S_UPD;
            end
            S_UPD, S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop        = 1'b0;
        key_rd_en    = 1'b0;
        rec_rd_en    = 1'b0;
        key_wr_en    = 1'b0;
        rec_wr_en    = 1'b0;
        load         = 1'b0;
        wr_addr      = idx_reg;
        rec_wr       = upd_rec;
        created_next = created_reg;
        matched_next = matched_reg;
        out_next     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                q_pop = q_valid;
            end
            S_SCAN:
            begin
                key_rd_en = 1'b1;
            end
            S_CMP:
            begin
            end
            S_REC:
            begin
                rec_rd_en = 1'b1;
            end
            S_UPD:
            begin
                load         = out_free;
                rec_wr_en    = out_free;
                matched_next = (matched_reg == '1) ? matched_reg : matched_reg + 1'b1;
                out_next.status = ST_UPDATE;
                out_next.slot   = 8'(idx_reg);
                out_next.rec    = upd_rec;
            end
            S_DECIDE:
            begin
                load    = out_free;
                wr_addr = SLOT_W'(next_free_reg);
                rec_wr  = new_rec;
                if (has_room)
                begin
                    key_wr_en       = out_free;
                    rec_wr_en       = out_free;
                    created_next    = (created_reg == '1) ? created_reg : created_reg + 1'b1;
                    out_next.status = ST_NEW;
                    out_next.slot   = 8'(next_free_reg);
                    out_next.rec    = new_rec;
                end
                else
                begin
                    out_next.status = ST_FULL;
                end
            end
            default:
            begin
            end
        endcase
        out_next.new_flow_count = created_next;
        out_next.update_count   = matched_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            next_free_reg <= '0;
            created_reg   <= '0;
            matched_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == S_CMP && !key_hit && !scan_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (load)
            begin
                created_reg <= created_next;
                matched_reg <= matched_next;
                if (state_reg == S_DECIDE && has_room)
                begin
                    next_free_reg <= next_free_reg + 1'b1;
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (load)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> CNT_W'(idx_reg) < next_free_reg)
        else $error("scan index past last allocated slot");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ST_FULL |->
            out_reg.slot == '0 && out_reg.rec.packets == '0)
        else $error("table full result carries a record");

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE && load && has_room |=>
            next_free_reg == $past(next_free_reg) + 1'b1)
        else $error("allocation did not advance free pointer");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= CNT_W'(SLOTS))
        else $error("free pointer beyond table");
`endif

endmodule

### rtl/flow_record_table.sv
// top level of the flow record table
// Flow record table: each input beat summarizes one packet. Its key is compared
// against the keys of all allocated slots by a scan of the key memory, one slot
// at a time (address then compare), stopping at the first hit; a hit reads
// the record memory, updates counts and bounds and writes it back, a miss
// allocates the next free slot or reports table full. Once the back end takes an
// item from the queue it stays busy through the scan and the final update,
// allocation or full report, and waits there while a stalled result has not
// yet left; a beat is registered in the queue before the back end can take it. A
// two-beat queue lets packets be taken while the scan runs, and the result
// register lets the next item start while a result waits. slots_in_use may be
// written at any time the block is idle; slots once allocated stay valid until
// reset.
module flow_record_table import frt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] key_low,
    input  logic [39:0] key_high,
    input  logic [31:0] ts_seconds,
    input  logic [19:0] ts_micros,
    input  logic [15:0] packet_length,
    input  logic [7:0]  hop_limit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  slot,
    output logic [31:0] packet_total,
    output logic [39:0] byte_total,
    output logic [15:0] min_length,
    output logic [15:0] max_length,
    output logic [7:0]  min_hops,
    output logic [7:0]  max_hops,
    output logic [31:0] start_seconds,
    output logic [19:0] start_micros,
    output logic [31:0] new_flow_count,
    output logic [31:0] update_count
);

    logic       cfg_write;
    logic [8:0] slots_reg;
    logic       q_valid;
    item_t      q_item;
    logic       q_pop;
    res_t       res;

    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= 9'd256;
        end
        else if (cfg_write)
        begin
            slots_reg <= cfg_data;
        end
    end

    frt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .key_low       (key_low),
        .key_high      (key_high),
        .ts_seconds    (ts_seconds),
        .ts_micros     (ts_micros),
        .packet_length (packet_length),
        .hop_limit     (hop_limit),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    frt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .slots_in_use (slots_reg),
        .res_valid    (out_valid),
        .res          (res),
        .res_stall    (out_stall)
    );

    assign status         = res.status;
    assign slot           = res.slot;
    assign packet_total   = res.rec.packets;
    assign byte_total     = res.rec.bytes;
    assign min_length     = res.rec.len_min;
    assign max_length     = res.rec.len_max;
    assign min_hops       = res.rec.hop_min;
    assign max_hops       = res.rec.hop_max;
    assign start_seconds  = res.rec.start_seconds;
    assign start_micros   = res.rec.start_micros;
    assign new_flow_count = res.new_flow_count;
    assign update_count   = res.update_count;

endmodule
